// ===== sv/cse_pkg.sv =====
// ----------------------------------------------------------------------------
// cse_pkg
// Shared types, widths and helpers for the cosine similarity engine.
// ----------------------------------------------------------------------------
package cse_pkg;

  localparam int ELEM_BITS = 16;                    // element width, Q1.15
  localparam int PROD_W    = 2 * ELEM_BITS;         // one element product
  localparam int ACC_W     = 48;                    // accumulator width
  localparam int HALF_W    = ACC_W / 2;             // multiplier slice width
  localparam int SQ_W      = 2 * ACC_W;             // full 48x48 product
  localparam int NUM_W     = SQ_W + 2 * ELEM_BITS;  // (|dot| << 16)^2
  localparam int SRCH_W    = NUM_W + 2;             // signed search datapath
  localparam int K_W       = 16;                    // quotient magnitude 0..32768
  localparam int KIDX_W    = 4;                     // bit index into the quotient
  localparam int MUL_STEPS = 4;                     // slice products per multiply
  localparam int MCNT_W    = 3;
  localparam int Q_DEPTH   = 2;                     // sums queue depth
  localparam int Q_PTR_W   = 1;
  localparam int Q_CNT_W   = 2;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct packed {
    logic signed [ELEM_BITS-1:0] elem_a;
    logic signed [ELEM_BITS-1:0] elem_b;
    logic                        last_element;
  } cse_in_t;

  typedef struct packed {
    logic signed [ELEM_BITS-1:0] similarity;
    logic                        degenerate;
  } cse_out_t;

  // Final sums of one vector pair, handed from the front to the back.
  typedef struct packed {
    logic signed [ACC_W-1:0] dot;
    logic signed [ACC_W-1:0] norm_a;
    logic signed [ACC_W-1:0] norm_b;
  } cse_sums_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_N,
    S_MUL_P,
    S_CHECK,
    S_ADD1,
    S_ADD2,
    S_CMP,
    S_FIN,
    S_OUT
  } cse_state_t;

  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0]  acc,
    input logic signed [PROD_W-1:0] p
  );
    logic [ACC_W:0] s;
    s = {acc[ACC_W-1], acc} + {{(ACC_W + 1 - PROD_W){p[PROD_W-1]}}, p};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? ACC_MIN : ACC_MAX;
    end
    return s[ACC_W-1:0];
  endfunction

endpackage

// ===== sv/cse_front.sv =====
// ----------------------------------------------------------------------------
// cse_front
// Takes one pair per unstalled cycle, forms the three products and adds them
// into saturating accumulators. A last element pushes the sums to the queue.
// ----------------------------------------------------------------------------
module cse_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  cse_pkg::cse_in_t  item,
  output logic              q_push,
  output cse_pkg::cse_sums_t q_data,
  input  logic              q_full
);
  import cse_pkg::*;

  logic                     s1_valid;
  logic                     s1_last;
  logic signed [PROD_W-1:0] s1_ab;
  logic signed [PROD_W-1:0] s1_aa;
  logic signed [PROD_W-1:0] s1_bb;
  logic                     s1_go;

  logic signed [ACC_W-1:0] dot;
  logic signed [ACC_W-1:0] norm_a;
  logic signed [ACC_W-1:0] norm_b;
  logic signed [ACC_W-1:0] dot_next;
  logic signed [ACC_W-1:0] norm_a_next;
  logic signed [ACC_W-1:0] norm_b_next;

  // The product stage only holds when a last element finds the queue full.
  assign s1_go      = !s1_last || !q_full;
  assign item_stall = s1_valid && !s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_last <= item.last_element;
      s1_ab   <= $signed(item.elem_a) * $signed(item.elem_b);
      s1_aa   <= $signed(item.elem_a) * $signed(item.elem_a);
      s1_bb   <= $signed(item.elem_b) * $signed(item.elem_b);
    end
  end

  assign dot_next    = sat_add(dot, s1_ab);
  assign norm_a_next = sat_add(norm_a, s1_aa);
  assign norm_b_next = sat_add(norm_b, s1_bb);

  always_ff @(posedge clk) begin
    if (rst) begin
      dot    <= '0;
      norm_a <= '0;
      norm_b <= '0;
    end else if (s1_valid && s1_go) begin
      if (s1_last) begin
        dot    <= '0;
        norm_a <= '0;
        norm_b <= '0;
      end else begin
        dot    <= dot_next;
        norm_a <= norm_a_next;
        norm_b <= norm_b_next;
      end
    end
  end

  assign q_push        = s1_valid && s1_last && !q_full;
  assign q_data.dot    = dot_next;
  assign q_data.norm_a = norm_a_next;
  assign q_data.norm_b = norm_b_next;

endmodule

// ===== sv/cse_queue.sv =====
// ----------------------------------------------------------------------------
// cse_queue
// Short queue of finished vector sums between the front and the back.
// ----------------------------------------------------------------------------
module cse_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  cse_pkg::cse_sums_t push_data,
  output logic               full,
  input  logic               pop,
  output cse_pkg::cse_sums_t head,
  output logic               empty
);
  import cse_pkg::*;

  cse_sums_t            mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;

  assign full  = (count == Q_CNT_W'(Q_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/cse_back.sv =====
// ----------------------------------------------------------------------------
// cse_back
// Turns one set of sums into a Q1.15 similarity: squares the dot product and
// multiplies the norms on a shared 24x24 slice multiplier, then finds the
// rounded quotient one bit per pass with shift-and-add updates.
// ----------------------------------------------------------------------------
module cse_back (
  input  logic               clk,
  input  logic               rst,
  input  cse_pkg::cse_sums_t head,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               result_valid,
  input  logic               result_stall,
  output cse_pkg::cse_out_t  result
);
  import cse_pkg::*;

  cse_state_t state;
  cse_state_t state_next;

  // Shared multiplier.
  logic [ACC_W-1:0]  op_x;
  logic [ACC_W-1:0]  op_y;
  logic [HALF_W-1:0] sl_x;
  logic [HALF_W-1:0] sl_y;
  logic [ACC_W-1:0]  pp;
  logic [1:0]        psh;
  logic [1:0]        psh_next;
  logic [SQ_W-1:0]   macc;
  logic [SQ_W-1:0]   pp_shifted;
  logic [SQ_W-1:0]   macc_sum;
  logic [MCNT_W-1:0] mcnt;

  // Operands of the current vector.
  logic              neg;
  logic [ACC_W-1:0]  na;
  logic [ACC_W-1:0]  nb;
  logic [NUM_W-1:0]  nreg;
  logic [SQ_W-1:0]   preg;
  logic              deg;

  // Quotient search: x is 2k-1, x2p holds x*x*P and xp holds x*P.
  logic signed [SRCH_W-1:0] pw;
  logic signed [SRCH_W-1:0] x2p;
  logic signed [SRCH_W-1:0] xp;
  logic signed [SRCH_W-1:0] cand1;
  logic signed [SRCH_W-1:0] cand;
  logic signed [SRCH_W-1:0] xpc;
  logic [K_W-1:0]           k;
  logic [KIDX_W-1:0]        j;
  logic [KIDX_W:0]          sh_xp;
  logic [KIDX_W+1:0]        sh_p;
  logic [KIDX_W:0]          sh_d;
  logic                     take;
  logic [ELEM_BITS-1:0]     sim;

  always_comb begin
    case (mcnt)
      3'd0:    begin sl_x = op_x[HALF_W-1:0];     sl_y = op_y[HALF_W-1:0];     psh_next = 2'd0; end
      3'd1:    begin sl_x = op_x[HALF_W-1:0];     sl_y = op_y[ACC_W-1:HALF_W]; psh_next = 2'd1; end
      3'd2:    begin sl_x = op_x[ACC_W-1:HALF_W]; sl_y = op_y[HALF_W-1:0];     psh_next = 2'd1; end
      default: begin sl_x = op_x[ACC_W-1:HALF_W]; sl_y = op_y[ACC_W-1:HALF_W]; psh_next = 2'd2; end
    endcase
  end

  always_comb begin
    case (psh)
      2'd0:    pp_shifted = {{(SQ_W - ACC_W){1'b0}}, pp};
      2'd1:    pp_shifted = {{(SQ_W - ACC_W - HALF_W){1'b0}}, pp, {HALF_W{1'b0}}};
      default: pp_shifted = {pp, {ACC_W{1'b0}}};
    endcase
  end

  assign macc_sum = macc + pp_shifted;

  assign pw    = $signed({{(SRCH_W - SQ_W){1'b0}}, preg});
  assign sh_xp = {1'b0, j} + (KIDX_W + 1)'(2);
  assign sh_p  = {1'b0, j, 1'b0} + (KIDX_W + 2)'(2);
  assign sh_d  = {1'b0, j} + (KIDX_W + 1)'(1);
  // A candidate above 32768 is never in range, so a set top bit ends the search.
  assign take  = !k[K_W-1] && ($signed({2'b00, nreg}) >= cand);

  always_comb begin
    if (neg) begin
      sim = ELEM_BITS'(-k);
    end else if (k[K_W-1]) begin
      sim = {1'b0, {(ELEM_BITS-1){1'b1}}};
    end else begin
      sim = k;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (!q_empty) state_next = S_MUL_N;
      S_MUL_N: if (mcnt == MCNT_W'(MUL_STEPS)) state_next = S_MUL_P;
      S_MUL_P: if (mcnt == MCNT_W'(MUL_STEPS)) state_next = S_CHECK;
      S_CHECK: state_next = (preg[SQ_W-1:1] == '0) ? S_FIN : S_ADD1;
      S_ADD1:  state_next = S_ADD2;
      S_ADD2:  state_next = S_CMP;
      S_CMP:   state_next = (j == '0) ? S_FIN : S_ADD1;
      S_FIN:   state_next = S_OUT;
      S_OUT:   if (!result_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    q_pop        = 1'b0;
    result_valid = 1'b0;
    case (state)
      S_IDLE:  q_pop = !q_empty;
      S_OUT:   result_valid = 1'b1;
      default: begin
        q_pop        = 1'b0;
        result_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        neg  <= head.dot[ACC_W-1];
        op_x <= head.dot[ACC_W-1] ? ACC_W'(-head.dot) : head.dot;
        op_y <= head.dot[ACC_W-1] ? ACC_W'(-head.dot) : head.dot;
        na   <= head.norm_a;
        nb   <= head.norm_b;
        macc <= '0;
        mcnt <= '0;
      end
      S_MUL_N, S_MUL_P: begin
        if (mcnt != MCNT_W'(MUL_STEPS)) begin
          pp   <= sl_x * sl_y;
          psh  <= psh_next;
          mcnt <= mcnt + 1'b1;
        end
        if (mcnt != '0) begin
          macc <= macc_sum;
        end
        if (mcnt == MCNT_W'(MUL_STEPS)) begin
          if (state == S_MUL_N) begin
            nreg <= {macc_sum, {(NUM_W - SQ_W){1'b0}}};
            op_x <= na;
            op_y <= nb;
            macc <= '0;
            mcnt <= '0;
          end else begin
            preg <= macc_sum;
          end
        end
      end
      S_CHECK: begin
        deg <= (preg[SQ_W-1:1] == '0);
        x2p <= pw;
        xp  <= -pw;
        k   <= '0;
        j   <= KIDX_W'(K_W - 1);
      end
      S_ADD1: begin
        cand1 <= x2p + (xp <<< sh_xp);
      end
      S_ADD2: begin
        cand <= cand1 + (pw <<< sh_p);
        xpc  <= xp + (pw <<< sh_d);
      end
      S_CMP: begin
        if (take) begin
          k[j] <= 1'b1;
          x2p  <= cand;
          xp   <= xpc;
        end
        j <= j - 1'b1;
      end
      S_FIN: begin
        result.degenerate <= deg;
        result.similarity <= deg ? '0 : $signed(sim);
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/cosine_similarity_engine.sv =====
// ----------------------------------------------------------------------------
// cosine_similarity_engine
// Streams element pairs of two vectors and returns their cosine similarity
// in Q1.15 after the last pair of a vector arrives.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+--------------------------
//   item     | in        | item_valid/stall    | elem_a, elem_b, last
//   result   | out       | result_valid/stall  | similarity, degenerate
//
// The front takes one element pair per cycle unless stalled; its three 16x16
// multipliers and saturating accumulators set that rate.
// The back forms two 48x48 products on one 24x24 slice multiplier, then runs
// a 16-pass quotient search through S_ADD1, S_ADD2 and S_CMP, skipped when
// the norm product is degenerate; it pops new sums only from S_IDLE.
// A two-entry queue holds finished sums; item_stall rises only when a last
// element finds it full. Reset is synchronous and clears all control state.
// ----------------------------------------------------------------------------
module cosine_similarity_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  cse_pkg::cse_in_t  item,
  output logic              result_valid,
  input  logic              result_stall,
  output cse_pkg::cse_out_t result
);
  import cse_pkg::*;

  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_empty;
  cse_sums_t q_in;
  cse_sums_t q_head;

  cse_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_push     (q_push),
    .q_data     (q_in),
    .q_full     (q_full)
  );

  cse_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  cse_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (q_head),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

`ifndef NO_ASSERTIONS
  // The front may only hold off items because the queue has no room.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> q_full)
    else $error("item stalled while the sums queue had room");

  // Sums must never be written into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("sums pushed into a full queue");

  // The back must not take sums from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("sums popped from an empty queue");

  // A degenerate result always carries a zero similarity.
  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.degenerate |-> result.similarity == '0)
    else $error("degenerate result with nonzero similarity");
`endif

endmodule
